/* src/rbnf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbnf_pkg
// Shared widths, constants, types and helpers of the ray/box face hit block.
// ----------------------------------------------------------------------------
package rbnf_pkg;

	localparam int COORD_W   = 32;
	localparam int DIST_W    = 40;
	localparam int FACE_W    = 3;
	localparam int NUM_FACES = 6;
	localparam int NUM_AXES  = 3;
	localparam int MAG_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 57;
	localparam int PT_W      = 58;

	localparam logic [DIST_W-1:0] FAR_RESET = 40'd6553600000;
	localparam logic signed [PT_W-1:0] ONE_PT = 58'sd65536;
	localparam logic signed [PT_W-1:0] MAX32_PT = 58'sd2147483647;
	localparam logic signed [PT_W-1:0] MIN32_PT = -58'sd2147483648;

	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_W-1:0] o;
		logic [NUM_AXES-1:0][MAG_W-1:0]   a;
		logic [NUM_AXES-1:0]              neg;
		logic [DIST_W-1:0]                bound;
		logic [NUM_FACES-1:0]             skip;
	} side_t;

	typedef struct packed {
		logic                          valid;
		logic [DIST_W-1:0]             t;
		logic [FACE_W-1:0]             face;
		logic [NUM_AXES-1:0][PT_W-1:0] p;
	} cand_t;

	// a valid later candidate wins over an invalid one, or when strictly nearer
	function automatic cand_t pick(cand_t a, cand_t b);
		pick = (b.valid && (!a.valid || (b.t < a.t))) ? b : a;
	endfunction

	function automatic logic [COORD_W-1:0] sat32(logic [PT_W-1:0] v);
		logic signed [PT_W-1:0] s;
		s = $signed(v);
		if (s > MAX32_PT)
			sat32 = MAX32_PT[COORD_W-1:0];
		else if (s < MIN32_PT)
			sat32 = MIN32_PT[COORD_W-1:0];
		else
			sat32 = s[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/rbnf_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbnf_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbnf_div #(
	parameter int QW = rbnf_pkg::DIST_W,
	parameter int DW = rbnf_pkg::MAG_W
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] n_hi,
	input  wire logic [QW-1:0] n_lo,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quot
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nlo_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [QW-1:0] nl_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign r_in  = n_hi;
			assign nl_in = n_lo;
			assign q_in  = '0;
			assign d_in  = den;
		end else begin : g_next
			assign r_in  = rem_s[i-1];
			assign nl_in = nlo_s[i-1];
			assign q_in  = quo_s[i-1];
			assign d_in  = den_s[i-1];
		end

		always_comb begin
			trial = {r_in, nl_in[QW-1]};
			diff  = trial - {1'b0, d_in};
			ge    = trial >= {1'b0, d_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nlo_s[i] <= {nl_in[QW-2:0], 1'b0};
				quo_s[i] <= {q_in[QW-2:0], ge};
				den_s[i] <= d_in;
			end
		end
	end

	assign quot = quo_s[QW-1];

endmodule
`default_nettype wire

/* src/rbnf_along.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbnf_along
// One coordinate of origin + t * dir, two register stages.
// ----------------------------------------------------------------------------
module rbnf_along (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [rbnf_pkg::DIST_W-1:0]    t,
	input  wire logic [rbnf_pkg::MAG_W-1:0]     a,
	input  wire logic                           neg,
	input  wire logic [rbnf_pkg::COORD_W-1:0]   o,
	output logic      [rbnf_pkg::PT_W-1:0]      p
);

	localparam int FW = rbnf_pkg::FRAC_W;
	localparam int TW = rbnf_pkg::DIST_W;
	localparam int AW = rbnf_pkg::MAG_W;
	localparam int CW = rbnf_pkg::COORD_W;
	localparam int PW = rbnf_pkg::PT_W;
	localparam int MW = rbnf_pkg::PROD_W;

	logic [TW-FW+AW-1:0] ph_s1;
	logic [FW+AW-1:0]    pl_s1;
	logic                neg_s1;
	logic [CW-1:0]       o_s1;
	logic [MW-1:0]       m;
	logic [PW-1:0]       ox;
	logic [PW-1:0]       p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= t[TW-1:FW] * a;
			pl_s1  <= t[FW-1:0] * a;
			neg_s1 <= neg;
			o_s1   <= o;
		end
	end

	always_comb begin
		m  = {1'b0, ph_s1} + MW'(pl_s1[FW+AW-1:FW]);
		ox = {{(PW-CW){o_s1[CW-1]}}, o_s1};
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s2 <= neg_s1 ? ox - {1'b0, m} : ox + {1'b0, m};
	end

	assign p = p_s2;

endmodule
`default_nettype wire

/* src/rbnf_select.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbnf_select
// Nearest-face reduction over the six candidates and the result register.
// ----------------------------------------------------------------------------
module rbnf_select (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         beat_valid,
	input  wire rbnf_pkg::cand_t              cand [rbnf_pkg::NUM_FACES],
	output logic                              res_valid,
	output logic                              hit,
	output logic [rbnf_pkg::FACE_W-1:0]       face,
	output logic [rbnf_pkg::DIST_W-1:0]       distance,
	output logic [rbnf_pkg::COORD_W-1:0]      point_x,
	output logic [rbnf_pkg::COORD_W-1:0]      point_y,
	output logic [rbnf_pkg::COORD_W-1:0]      point_z
);

	rbnf_pkg::cand_t pair_s1 [3];
	rbnf_pkg::cand_t best;
	logic            valid_s1;
	logic            valid_q;
	logic            hit_q;
	logic [rbnf_pkg::FACE_W-1:0]  face_q;
	logic [rbnf_pkg::DIST_W-1:0]  dist_q;
	logic [rbnf_pkg::COORD_W-1:0] px_q, py_q, pz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= beat_valid;
			valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1[0] <= rbnf_pkg::pick(cand[0], cand[1]);
			pair_s1[1] <= rbnf_pkg::pick(cand[2], cand[3]);
			pair_s1[2] <= rbnf_pkg::pick(cand[4], cand[5]);
		end
	end

	always_comb best = rbnf_pkg::pick(rbnf_pkg::pick(pair_s1[0], pair_s1[1]), pair_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= best.valid;
			face_q <= best.valid ? best.face : '0;
			dist_q <= best.valid ? best.t : '0;
			px_q   <= best.valid ? rbnf_pkg::sat32(best.p[0]) : '0;
			py_q   <= best.valid ? rbnf_pkg::sat32(best.p[1]) : '0;
			pz_q   <= best.valid ? rbnf_pkg::sat32(best.p[2]) : '0;
		end
	end

	assign res_valid = valid_q;
	assign hit       = hit_q;
	assign face      = face_q;
	assign distance  = dist_q;
	assign point_x   = px_q;
	assign point_y   = py_q;
	assign point_z   = pz_q;

endmodule
`default_nettype wire

/* src/ray_box_nearest_face_hit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_nearest_face_hit
// Nearest face hit of a model-space ray against the cube spanning -1..1.
// ----------------------------------------------------------------------------
// Accepts one ray every cycle while ray_stall is low and returns one result
// beat per ray, in order. Each ray passes through the six 40-stage
// pipelined dividers (one quotient bit per stage), followed by two multiply
// stages, a face check stage and two selection stages. When the result beat
// is stalled the whole pipeline holds and ray_stall rises. far_limit is the
// starting bound when prior_valid is low; write it only while no ray is in
// flight.
module ray_box_nearest_face_hit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [rbnf_pkg::DIST_W-1:0]       cfg_wdata,
	input  wire logic                              ray_valid,
	output logic                                   ray_stall,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      origin_x,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      origin_y,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      origin_z,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      dir_x,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      dir_y,
	input  wire logic [rbnf_pkg::COORD_W-1:0]      dir_z,
	input  wire logic                              prior_valid,
	input  wire logic [rbnf_pkg::DIST_W-1:0]       prior_distance,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic                                   hit,
	output logic [rbnf_pkg::FACE_W-1:0]            face,
	output logic [rbnf_pkg::DIST_W-1:0]            distance,
	output logic [rbnf_pkg::COORD_W-1:0]           point_x,
	output logic [rbnf_pkg::COORD_W-1:0]           point_y,
	output logic [rbnf_pkg::COORD_W-1:0]           point_z
);

	localparam int NF = rbnf_pkg::NUM_FACES;
	localparam int NA = rbnf_pkg::NUM_AXES;
	localparam int CW = rbnf_pkg::COORD_W;
	localparam int AW = rbnf_pkg::MAG_W;
	localparam int QW = rbnf_pkg::DIST_W;
	localparam int FW = rbnf_pkg::FRAC_W;
	localparam int PW = rbnf_pkg::PT_W;

	logic en;
	logic [QW-1:0] far_limit_q;

	logic                  valid_s1;
	logic [NA-1:0][CW-1:0] o_s1;
	logic [NA-1:0][CW-1:0] d_s1;
	logic [QW-1:0]         bound_s1;

	logic [NA-1:0][AW-1:0] a_c;
	logic [NA-1:0]         neg_c;
	logic [AW-1:0]         mag_c  [NF];
	logic [NF-1:0]         skip_c;

	logic                  valid_s2;
	rbnf_pkg::side_t       side_s2;
	logic [AW-1:0]         mag_s2 [NF];
	logic [AW-1:0]         den_s2 [NF];

	rbnf_pkg::side_t       dly_side_s  [QW];
	logic                  dly_valid_s [QW];

	logic [QW-1:0]         quot   [NF];
	rbnf_pkg::side_t       side_d;
	logic [NF-1:0]         pre_c;

	logic                  valid_s3, valid_s4, valid_s5;
	logic [NF-1:0]         pre_s3, pre_s4;
	logic [QW-1:0]         q_s3 [NF];
	logic [QW-1:0]         q_s4 [NF];
	logic [PW-1:0]         pt   [NF][NA];
	rbnf_pkg::cand_t       cand_s5 [NF];

	assign en        = !(res_valid && res_stall);
	assign ray_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			far_limit_q <= rbnf_pkg::FAR_RESET;
		else if (cfg_wen)
			far_limit_q <= cfg_wdata;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= ray_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1     <= {origin_z, origin_y, origin_x};
			d_s1     <= {dir_z, dir_y, dir_x};
			bound_s1 <= prior_valid ? prior_distance : far_limit_q;
		end
	end

	// plane numerators, magnitudes and skip conditions
	always_comb begin
		for (int k = 0; k < NA; k++) begin
			neg_c[k] = d_s1[k][CW-1];
			a_c[k]   = neg_c[k] ? (~d_s1[k] + 1'b1) : d_s1[k];
		end
	end

	for (genvar f = 0; f < NF; f++) begin : g_num
		localparam int AX = f % NA;
		localparam logic signed [CW+1:0] PLANE = (f < NA) ? 34'sd65536 : -34'sd65536;
		logic signed [CW+1:0] num;
		logic [CW+1:0]        num_mag;

		always_comb begin
			num       = PLANE - $signed({{2{o_s1[AX][CW-1]}}, o_s1[AX]});
			num_mag   = num[CW+1] ? -num : num;
			mag_c[f]  = num_mag[AW-1:0];
			skip_c[f] = (d_s1[AX] == '0) || (num == '0) || (num[CW+1] != neg_c[AX]) ||
			            ({24'b0, mag_c[f]} >= {a_c[AX], 24'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.o     <= o_s1;
			side_s2.a     <= a_c;
			side_s2.neg   <= neg_c;
			side_s2.bound <= bound_s1;
			side_s2.skip  <= skip_c;
			for (int f = 0; f < NF; f++) begin
				mag_s2[f] <= mag_c[f];
				den_s2[f] <= a_c[f % NA];
			end
		end
	end

	// dividers and matching side delay line
	for (genvar f = 0; f < NF; f++) begin : g_div
		rbnf_div #(
			.QW (QW),
			.DW (AW)
		) u_div (
			.clk  (clk),
			.en   (en),
			.n_hi (AW'(mag_s2[f][AW-1:QW-FW])),
			.n_lo ({mag_s2[f][QW-FW-1:0], {FW{1'b0}}}),
			.den  (den_s2[f]),
			.quot (quot[f])
		);
	end

	for (genvar i = 0; i < QW; i++) begin : g_dly
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dly_valid_s[i] <= 1'b0;
				else if (en)
					dly_valid_s[i] <= valid_s2;
			end
			always_ff @(posedge clk) begin
				if (en)
					dly_side_s[i] <= side_s2;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dly_valid_s[i] <= 1'b0;
				else if (en)
					dly_valid_s[i] <= dly_valid_s[i-1];
			end
			always_ff @(posedge clk) begin
				if (en)
					dly_side_s[i] <= dly_side_s[i-1];
			end
		end
	end

	assign side_d = dly_side_s[QW-1];

	always_comb begin
		for (int f = 0; f < NF; f++)
			pre_c[f] = !side_d.skip[f] && (quot[f] != '0) && (quot[f] < side_d.bound);
	end

	// hit points
	for (genvar f = 0; f < NF; f++) begin : g_pt
		for (genvar k = 0; k < NA; k++) begin : g_ax
			rbnf_along u_along (
				.clk (clk),
				.en  (en),
				.t   (quot[f]),
				.a   (side_d.a[k]),
				.neg (side_d.neg[k]),
				.o   (side_d.o[k]),
				.p   (pt[f][k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= dly_valid_s[QW-1];
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s3 <= pre_c;
			pre_s4 <= pre_s3;
			for (int f = 0; f < NF; f++) begin
				q_s3[f] <= quot[f];
				q_s4[f] <= q_s3[f];
			end
		end
	end

	// face square check
	for (genvar f = 0; f < NF; f++) begin : g_chk
		localparam int AX = f % NA;
		logic inside_sq;

		always_comb begin
			inside_sq = 1'b1;
			for (int k = 0; k < NA; k++) begin
				if (k != AX) begin
					if (($signed(pt[f][k]) < -rbnf_pkg::ONE_PT) ||
					    ($signed(pt[f][k]) > rbnf_pkg::ONE_PT))
						inside_sq = 1'b0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cand_s5[f].valid <= pre_s4[f] && inside_sq;
				cand_s5[f].t     <= q_s4[f];
				cand_s5[f].face  <= rbnf_pkg::FACE_W'(f);
				for (int k = 0; k < NA; k++)
					cand_s5[f].p[k] <= pt[f][k];
			end
		end
	end

	rbnf_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.beat_valid (valid_s5),
		.cand       (cand_s5),
		.res_valid  (res_valid),
		.hit        (hit),
		.face       (face),
		.distance   (distance),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z)
	);

	// no hit beat carries all zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !hit) |-> (face == '0 && distance == '0 && point_x == '0 &&
		                         point_y == '0 && point_z == '0))
		else $error("miss beat with non-zero fields");

	// a hit has a positive distance and a real face
	a_hit_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && hit) |-> (distance != '0 &&
		                        face < rbnf_pkg::FACE_W'(rbnf_pkg::NUM_FACES)))
		else $error("hit beat with bad face or distance");

	// input only held back by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall |-> (res_valid && res_stall))
		else $error("ray stalled without result back-pressure");

endmodule
`default_nettype wire
